// ----- hdl/bint_pkg.sv -----
// Shared types and constants of the binned interpolation table.
// Depends on nothing; the top level and the testbench import it.
package bint_pkg;

	// Request beat: one table load or one query
	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         entry_index;
		logic signed [15:0] entry_value;
		logic signed [23:0] query_time;
		logic signed [15:0] query_radius;
	} req_t;

	// Response beat: one answer per query
	typedef struct packed {
		logic signed [15:0] radius_out;
		logic signed [23:0] slope_out;
		logic signed [23:0] time_out;
	} rsp_t;

	// Operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_RADIUS = 2'd1;
	localparam logic [1:0] OP_SLOPE  = 2'd2;
	localparam logic [1:0] OP_TIME   = 2'd3;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_TIME_MIN    = 2'd0;
	localparam logic [1:0] REG_TIME_MAX    = 2'd1;
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;

	// Divider widths: signed dividend, unsigned divisor
	localparam int DIV_DW = 52;
	localparam int DIV_VW = 26;

endpackage

// ----- hdl/bint_ram.sv -----
// Generic single-write, single-read RAM with a registered read.
// Depends on nothing.
module bint_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/bint_div.sv -----
// Bit-serial floor divider: signed dividend by positive divisor, one bit a cycle.
// Depends on nothing; the top level sets the widths from bint_pkg.
module bint_div #(
	parameter int DW = 52,
	parameter int VW = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic [VW-1:0]        divisor,
	output logic                 done,
	output logic signed [DW-1:0] quotient,
	output logic [VW-1:0]        remainder
);

	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [DW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	// Trial subtraction of one restoring step
	always_comb begin
		trial = {rem_q, num_q[DW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Control: count the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: floor(a/b) of negative a is ~((~a)/b)
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			num_q <= dividend[DW-1] ? ~dividend : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = neg_q ? ~num_q : num_q;
	assign remainder = rem_q;

endmodule

// ----- hdl/binned_interpolation_table.sv -----
// Top level of the binned interpolation table: control sequencer and arithmetic.
// Depends on bint_pkg, bint_ram and bint_div.
//
// Channel | Direction | Handshake            | Beat
// req     | in        | req_valid/req_stall  | bint_pkg::req_t
// rsp     | out       | rsp_valid/rsp_stall  | bint_pkg::rsp_t
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load writes the RAM when it is accepted. A query that clamps passes S_FIRST,
// S_LAST and S_DISP to S_FIN, which registers rsp_valid. Each divider pass has 52 steps.
// Radius and slope queries inside the span run two passes (bin, then rounded quotient).
// A time query that does not clamp runs a binary search on the RAM read port and one
// pass. Reset clears control and sets configuration to defaults; table contents are
// undefined until loaded. A new request is taken while a finished response waits;
// a stalled response holds the sequencer before it hands over the next answer.
module binned_interpolation_table #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bint_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output bint_pkg::rsp_t  rsp_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [23:0]     cfg_data
);

	import bint_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam logic [6:0] N_CAP = (MAX_ENTRIES > 127) ? 7'd127 : 7'(MAX_ENTRIES);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_FIRST   = 4'd1;
	localparam logic [3:0] S_LAST    = 4'd2;
	localparam logic [3:0] S_DISP    = 4'd3;
	localparam logic [3:0] S_BINDIV  = 4'd4;
	localparam logic [3:0] S_BINWAIT = 4'd5;
	localparam logic [3:0] S_SRCH    = 4'd6;
	localparam logic [3:0] S_SCMP    = 4'd7;
	localparam logic [3:0] S_V0      = 4'd8;
	localparam logic [3:0] S_V1      = 4'd9;
	localparam logic [3:0] S_DV      = 4'd10;
	localparam logic [3:0] S_CALC1   = 4'd11;
	localparam logic [3:0] S_CALC2   = 4'd12;
	localparam logic [3:0] S_DIVGO   = 4'd13;
	localparam logic [3:0] S_DIVWAIT = 4'd14;
	localparam logic [3:0] S_FIN     = 4'd15;

	function automatic logic [AW-1:0] to_addr(input logic [6:0] v);
		logic [AW+6:0] e;
		e = {{AW{1'b0}}, v};
		return e[AW-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [52:0] v);
		if (v > 53'sd32767) begin
			return 16'sh7fff;
		end else if (v < -53'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [52:0] v);
		if (v > 53'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -53'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	// Configuration registers
	logic signed [23:0] time_min_q;
	logic signed [23:0] time_max_q;
	logic [6:0]         entry_count_q;

	// Sequencer state and operands
	logic [3:0]         state_q;
	logic [1:0]         op_q;
	logic signed [23:0] t_q;
	logic signed [15:0] r_q;
	logic [6:0]         n_q;
	logic signed [15:0] first_q;
	logic signed [15:0] last_q;
	logic [6:0]         lo_q;
	logic [6:0]         cnt_q;
	logic [6:0]         it_q;
	logic [6:0]         bin_q;
	logic [DIV_VW-1:0]  rem_q;
	logic [31:0]        pos_q;
	logic signed [15:0] v0_q;
	logic signed [16:0] dv_q;
	logic [23:0]        m1_q;
	logic signed [49:0] a_q;
	logic [DIV_VW-1:0]  d_q;
	rsp_t               res_q;
	rsp_t               rsp_data_q;
	logic               rsp_valid_q;

	// Combinational helpers
	logic [6:0]         nm1;
	logic [6:0]         cnt_in;
	logic [6:0]         n_in;
	logic signed [24:0] span;
	logic signed [24:0] t_off;
	logic               in_range;
	logic               req_acc;
	logic               out_free;
	logic [6:0]         step;
	logic [6:0]         bin_srch;
	logic signed [16:0] off_raw;
	logic [15:0]        off_c;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [15:0]        ram_rdata;
	logic signed [15:0] rd_val;
	logic               div_start;
	logic signed [DIV_DW-1:0] div_num;
	logic [DIV_VW-1:0]  div_den;
	logic               div_done;
	logic signed [DIV_DW-1:0] div_q;
	logic [DIV_VW-1:0]  div_rem;
	rsp_t               clamp_res;
	rsp_t               calc_res;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;
	assign rd_val    = $signed(ram_rdata);

	// Clamp the entry count into the usable range
	always_comb begin
		cnt_in = entry_count_q;
		if (cnt_in < 7'd2) begin
			n_in = 7'd2;
		end else if (cnt_in > N_CAP) begin
			n_in = N_CAP;
		end else begin
			n_in = cnt_in;
		end
	end

	// Derived operands
	always_comb begin
		nm1      = n_q - 7'd1;
		span     = 25'(time_max_q) - 25'(time_min_q);
		t_off    = 25'(t_q) - 25'(time_min_q);
		in_range = (t_q > time_min_q) && (t_q < time_max_q);
		step     = cnt_q >> 1;
		off_raw  = 17'(r_q) - 17'(v0_q);
		if (off_raw < 17'sd0) begin
			off_c = '0;
		end else if (off_raw > dv_q) begin
			off_c = dv_q[15:0];
		end else begin
			off_c = off_raw[15:0];
		end
		if (lo_q == 7'd0) begin
			bin_srch = 7'd0;
		end else if (lo_q - 7'd1 > nm1 - 7'd1) begin
			bin_srch = nm1 - 7'd1;
		end else begin
			bin_srch = lo_q - 7'd1;
		end
	end

	// Clamped answer of the dispatch step
	always_comb begin
		clamp_res = '0;
		if (op_q == OP_TIME) begin
			if (r_q <= first_q) begin
				clamp_res.time_out = time_min_q;
			end else if (r_q >= last_q) begin
				clamp_res.time_out = time_max_q;
			end
		end else if (op_q == OP_RADIUS && !in_range) begin
			clamp_res.radius_out = (t_q <= time_min_q) ? first_q : last_q;
		end
	end

	// Computed answer from the last divider pass
	always_comb begin
		calc_res = '0;
		unique case (op_q)
			OP_RADIUS: calc_res.radius_out = sat16(53'(v0_q) + 53'(div_q));
			OP_SLOPE:  calc_res.slope_out  = sat24(53'(div_q));
			default:   calc_res.time_out   = sat24(53'(time_min_q) + 53'(div_q));
		endcase
	end

	// Table memory: loads write on accept, the sequencer reads
	assign ram_we    = req_acc && (req_data.op == OP_LOAD)
		&& (32'(req_data.entry_index) < 32'(MAX_ENTRIES));
	assign ram_waddr = to_addr({1'b0, req_data.entry_index});

	always_comb begin
		unique case (state_q)
			S_FIRST: ram_raddr = to_addr(nm1);
			S_SRCH:  ram_raddr = to_addr(lo_q + step);
			S_V0:    ram_raddr = to_addr(bin_q);
			S_V1:    ram_raddr = to_addr(bin_q + 7'd1);
			default: ram_raddr = '0;
		endcase
	end

	bint_ram #(
		.WIDTH(16),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_data.entry_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divider operands: bin index as pos by span, or rounded quotient (2a+d)/(2d)
	always_comb begin
		div_start = (state_q == S_BINDIV) || (state_q == S_DIVGO);
		if (state_q == S_BINDIV) begin
			div_num = DIV_DW'(pos_q);
			div_den = DIV_VW'(span[23:0]);
		end else begin
			div_num = (DIV_DW'(a_q) <<< 1) + $signed(DIV_DW'(d_q));
			div_den = d_q << 1;
		end
	end

	bint_div #(
		.DW(DIV_DW),
		.VW(DIV_VW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_rem)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_min_q    <= 24'sd0;
			time_max_q    <= 24'sd12800;
			entry_count_q <= 7'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIME_MIN:    time_min_q    <= $signed(cfg_data);
				REG_TIME_MAX:    time_max_q    <= $signed(cfg_data);
				REG_ENTRY_COUNT: entry_count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req_data.op != OP_LOAD) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: state_q <= S_LAST;
				S_LAST:  state_q <= S_DISP;
				S_DISP: begin
					if (op_q == OP_TIME) begin
						state_q <= (r_q <= first_q || r_q >= last_q) ? S_FIN : S_SRCH;
					end else begin
						state_q <= in_range ? S_BINDIV : S_FIN;
					end
				end
				S_BINDIV: state_q <= S_BINWAIT;
				S_BINWAIT: begin
					if (div_done) begin
						state_q <= S_V0;
					end
				end
				S_SRCH:  state_q <= (cnt_q == 7'd0) ? S_V0 : S_SCMP;
				S_SCMP:  state_q <= S_SRCH;
				S_V0:    state_q <= S_V1;
				S_V1:    state_q <= S_DV;
				S_DV:    state_q <= S_CALC1;
				S_CALC1: begin
					state_q <= (op_q == OP_TIME && dv_q > 17'sd0) ? S_CALC2 : S_DIVGO;
				end
				S_CALC2: state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			rsp_data_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					op_q <= req_data.op;
					t_q  <= req_data.query_time;
					r_q  <= req_data.query_radius;
					n_q  <= n_in;
				end
			end
			S_FIRST: first_q <= rd_val;
			S_LAST:  last_q  <= rd_val;
			S_DISP: begin
				// Clamped answers, and operands for the bin search
				res_q <= clamp_res;
				if (op_q == OP_TIME) begin
					lo_q  <= 7'd0;
					cnt_q <= n_q;
				end
				pos_q <= 32'(t_off[23:0]) * 32'(nm1);
			end
			S_BINWAIT: begin
				if (div_done) begin
					bin_q <= (div_q > $signed(DIV_DW'(nm1 - 7'd1))) ? nm1 - 7'd1 : div_q[6:0];
					rem_q <= div_rem;
				end
			end
			S_SRCH: begin
				it_q <= lo_q + step;
				if (cnt_q == 7'd0) begin
					bin_q <= bin_srch;
				end
			end
			S_SCMP: begin
				// Advance the lower bound or shrink the window
				if (rd_val < r_q) begin
					lo_q  <= it_q + 7'd1;
					cnt_q <= cnt_q - step - 7'd1;
				end else begin
					cnt_q <= step;
				end
			end
			S_V1: v0_q <= rd_val;
			S_DV: dv_q <= 17'(rd_val) - 17'(v0_q);
			S_CALC1: begin
				unique case (op_q)
					OP_RADIUS: begin
						a_q <= 50'(dv_q) * 50'($signed({1'b0, rem_q}));
						d_q <= DIV_VW'(span[23:0]);
					end
					OP_SLOPE: begin
						a_q <= (50'(dv_q) * 50'($signed({1'b0, nm1}))) <<< 16;
						d_q <= DIV_VW'(span[23:0]);
					end
					default: begin
						if (dv_q > 17'sd0) begin
							m1_q <= 24'(bin_q) * 24'(dv_q[15:0]) + 24'(off_c);
							d_q  <= DIV_VW'(nm1) * DIV_VW'(dv_q[15:0]);
						end else begin
							a_q <= 50'(span) * 50'($signed({1'b0, bin_q}));
							d_q <= DIV_VW'(nm1);
						end
					end
				endcase
			end
			S_CALC2: a_q <= 50'(span) * 50'($signed({1'b0, m1_q}));
			S_DIVWAIT: begin
				if (div_done) begin
					res_q <= calc_res;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench of binned_interpolation_table: directed and random loads and queries checked
// against a behavioral predictor. Depends on bint_pkg and the block's RTL.
module tb;
	import bint_pkg::*;

	// Predicted table state and configuration, and the store of pending answers
	class interp_scoreboard;
		logic signed [23:0] t_min;
		logic signed [23:0] t_max;
		logic [6:0] n_cfg;
		longint table_r[64];
		rsp_t pending[$];
		int errors;

		function void clear();
			t_min = 24'sd0;
			t_max = 24'sd12800;
			n_cfg = 7'd2;
			foreach (table_r[i]) table_r[i] = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] val);
			if (idx == REG_TIME_MIN) t_min = val;
			else if (idx == REG_TIME_MAX) t_max = val;
			else if (idx == REG_ENTRY_COUNT) n_cfg = val[6:0];
		endfunction

		function longint fdiv(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
			return q;
		endfunction

		function longint rdiv(longint a, longint b);
			return fdiv(2 * a + b, 2 * b);
		endfunction

		function longint clip(longint v, int w);
			longint hi;
			hi = (longint'(1) <<< (w - 1)) - 1;
			return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 50) $display("tb: mismatch: %s", msg);
		endfunction

		// Note an accepted request; queries queue one expected answer
		function void note_request(req_t rq);
			longint n, nm1, span, first, last, t, r, pos, bin, rem, v0, dv;
			longint lo, cnt, stp, it, off;
			rsp_t ans;
			n = n_cfg < 2 ? 2 : (n_cfg > 64 ? 64 : longint'(n_cfg));
			nm1 = n - 1;
			span = longint'(t_max) - longint'(t_min);
			first = table_r[0];
			last = table_r[n - 1];
			ans = '0;
			if (rq.op == OP_LOAD) begin
				table_r[rq.entry_index] = longint'(rq.entry_value);
				return;
			end
			if (rq.op != OP_TIME) begin
				t = longint'(rq.query_time);
				if (t > t_min && t < t_max) begin
					pos = (t - t_min) * nm1;
					bin = pos / span;
					rem = pos % span;
					if (bin > nm1 - 1) bin = nm1 - 1;
					v0 = table_r[bin];
					dv = table_r[bin + 1] - v0;
					if (rq.op == OP_RADIUS)
						ans.radius_out = 16'(clip(v0 + rdiv(dv * rem, span), 16));
					else
						ans.slope_out = 24'(clip(rdiv(dv * nm1 * 65536, span), 24));
				end else if (rq.op == OP_RADIUS) begin
					ans.radius_out = 16'((t <= t_min) ? first : last);
				end
			end else begin
				r = longint'(rq.query_radius);
				if (r <= first) ans.time_out = t_min;
				else if (r >= last) ans.time_out = t_max;
				else begin
					lo = 0;
					cnt = n;
					while (cnt > 0) begin
						stp = cnt / 2;
						it = lo + stp;
						if (table_r[it] < r) begin
							lo = it + 1;
							cnt -= stp + 1;
						end else begin
							cnt = stp;
						end
					end
					bin = lo - 1;
					if (bin < 0) bin = 0;
					if (bin > nm1 - 1) bin = nm1 - 1;
					v0 = table_r[bin];
					dv = table_r[bin + 1] - v0;
					if (dv > 0) begin
						off = r - v0;
						if (off < 0) off = 0;
						if (off > dv) off = dv;
						ans.time_out = 24'(clip(longint'(t_min)
							+ rdiv(span * (bin * dv + off), nm1 * dv), 24));
					end else begin
						ans.time_out = 24'(clip(longint'(t_min) + rdiv(span * bin, nm1), 24));
					end
				end
			end
			pending.push_back(ans);
		endfunction

		// Compare one answer beat with the oldest expectation
		function void check_answer(rsp_t got);
			rsp_t exp_r;
			if (pending.size() == 0) begin
				report("answer with nothing pending");
				return;
			end
			exp_r = pending.pop_front();
			if (got.radius_out !== exp_r.radius_out)
				report($sformatf("radius_out %0d, predicted %0d", got.radius_out,
					exp_r.radius_out));
			if (got.slope_out !== exp_r.slope_out)
				report($sformatf("slope_out %0d, predicted %0d", got.slope_out,
					exp_r.slope_out));
			if (got.time_out !== exp_r.time_out)
				report($sformatf("time_out %0d, predicted %0d", got.time_out,
					exp_r.time_out));
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic rand_stall_on = 1'b1;
	int idle_cycles = 0;
	int sent_items = 0;
	interp_scoreboard sb;

	binned_interpolation_table dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 150);
	endfunction

	// Sample answers and drive the receiver's stall
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_answer(rsp_data);
	end
	always @(negedge clk) begin
		if (rand_stall_on && gap_len() > 2) rsp_stall <= 1'b1;
		else rsp_stall <= 1'b0;
	end

	// Count cycles with no accepted beat
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
			(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Present one request beat; valid stays up when the next beat follows at once
	task automatic send_request(req_t rq);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= rq;
		do @(posedge clk); while (req_stall);
		sb.note_request(rq);
		sent_items++;
	endtask

	// Drop request valid after the last beat
	task automatic req_idle();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		req_idle();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		req_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_entry(int idx, int val);
		req_t rq;
		rq = '0;
		rq.op = OP_LOAD;
		rq.entry_index = 6'(idx);
		rq.entry_value = 16'(val);
		send_request(rq);
	endtask

	// Fill every entry; sorted or not, steep or gentle
	task automatic fill_table(bit sorted, int stepmax);
		int v;
		v = $urandom_range(0, 65535) - 32768;
		if (sorted) v = -32768 + $urandom_range(0, 2000);
		for (int i = 0; i < 64; i++) begin
			if (sorted) begin
				v += $urandom_range(0, stepmax);
				if (v > 32767) v = 32767;
			end else begin
				v = $urandom_range(0, 65535) - 32768;
			end
			load_entry(i, v);
		end
	endtask

	task automatic query(logic [1:0] op, int t, int r);
		req_t rq;
		rq = '0;
		rq.op = op;
		rq.entry_index = 6'($urandom());
		rq.entry_value = 16'($urandom());
		rq.query_time = 24'(t);
		rq.query_radius = 16'(r);
		send_request(rq);
	endtask

	function int rand_time();
		int lo, hi, p;
		p = $urandom_range(0, 9);
		lo = sb.t_min;
		hi = sb.t_max;
		if (p == 0) return $urandom_range(0, 24'hFFFFFF) - 8388608;
		if (p == 1) return lo;
		if (p == 2) return hi;
		if (hi <= lo) return lo + $urandom_range(0, 200) - 100;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Mostly radii between the first and last entry, now and then any value
	function int rand_radius();
		longint a, b;
		a = sb.table_r[0];
		b = sb.table_r[63];
		if ($urandom_range(0, 9) == 0 || b < a)
			return int'($urandom_range(0, 65535)) - 32768;
		return int'(a) + int'($urandom_range(0, 32'(b - a + 1)));
	endfunction

	initial begin
		int ph, cnt;
		int tmin_v, tmax_v;
		req_t rq;
		sb = new();
		sb.clear();
		rq = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Directed: extremes and every operation with reset config
		load_entry(0, -32768);
		load_entry(1, 32767);
		query(OP_RADIUS, -8388608, 0);
		query(OP_RADIUS, 8388607, 0);
		query(OP_RADIUS, 6400, 0);
		query(OP_SLOPE, 6400, 0);
		query(OP_SLOPE, 0, 0);
		query(OP_TIME, 0, -32768);
		query(OP_TIME, 0, 32767);
		query(OP_TIME, 0, 5);
		load_entry(1, -32768);
		query(OP_TIME, 0, 5);
		wait_drained();
		write_reg(REG_TIME_MIN, 24'h800000);
		write_reg(REG_TIME_MAX, 24'h7FFFFF);
		write_reg(REG_ENTRY_COUNT, 24'd64);
		fill_table(1, 1200);
		query(OP_RADIUS, 100, 0);
		query(OP_SLOPE, -5000000, 0);
		query(OP_TIME, 0, 0);
		wait_drained();
		// Reversed span, then zero span, counts out of range
		write_reg(REG_TIME_MIN, 24'd1000);
		write_reg(REG_TIME_MAX, 24'd500);
		write_reg(REG_ENTRY_COUNT, 24'd0);
		query(OP_RADIUS, 700, 0);
		query(OP_SLOPE, 700, 0);
		query(OP_TIME, 0, $urandom_range(0, 65535) - 32768);
		wait_drained();
		write_reg(REG_TIME_MAX, 24'd1000);
		write_reg(REG_ENTRY_COUNT, 24'd127);
		query(OP_TIME, 0, 0);
		wait_drained();

		// Random phases: new config, table fill, then queries
		ph = 0;
		while (sent_items < 1400) begin
			rand_stall_on = (ph % 4 != 3);
			case ($urandom_range(0, 3))
				0: begin
					tmin_v = -8388608;
					tmax_v = 8388607;
				end
				1: begin
					tmin_v = $urandom_range(0, 40000) - 20000;
					tmax_v = tmin_v + $urandom_range(1, 30000);
				end
				2: begin
					tmin_v = $urandom_range(0, 24'hFFFFFF) - 8388608;
					tmax_v = $urandom_range(0, 24'hFFFFFF) - 8388608;
				end
				default: begin
					tmin_v = $urandom_range(0, 2000);
					tmax_v = tmin_v + $urandom_range(0, 3) * 64;
				end
			endcase
			write_reg(REG_TIME_MIN, 24'(tmin_v));
			write_reg(REG_TIME_MAX, 24'(tmax_v));
			write_reg(REG_ENTRY_COUNT, 24'(($urandom_range(0, 5) == 0) ?
				$urandom_range(0, 127) : $urandom_range(2, 64)));
			fill_table($urandom_range(0, 4) != 0, $urandom_range(0, 4) == 0 ? 60000 : 900);
			cnt = $urandom_range(20, 50);
			for (int k = 0; k < cnt; k++) begin
				if ($urandom_range(0, 15) == 0) begin
					load_entry($urandom_range(0, 63), $urandom_range(0, 65535) - 32768);
				end else begin
					rq.op = 2'($urandom_range(1, 3));
					query(rq.op, rand_time(), rand_radius());
				end
			end
			wait_drained();
			ph++;
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
